>>> rtl/core/ritoa_pkg.sv
`timescale 1ns / 1ps

package ritoa_pkg;

  // Width of the converted value unless the top level is told otherwise.
  localparam int VALUE_WIDTH_DEF = 32;

  // Fixed field widths on the ports.
  localparam int VALUE_IN_W = 32;
  localparam int RADIX_W    = 5;
  localparam int CHAR_W     = 7;
  localparam int S_DATA_W   = 40;
  localparam int M_DATA_W   = 8;

  // Valid bases.
  localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd26;

  // Character mapping.
  localparam logic [CHAR_W-1:0] ASCII_ZERO = 7'h30;
  localparam logic [CHAR_W-1:0] ASCII_A    = 7'h41;
  localparam logic [RADIX_W-1:0] DIGIT_NINE = 5'd9;
  localparam logic [RADIX_W-1:0] DIGIT_TEN  = 5'd10;

  // Depth of the queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  // Quotient bits retired per cycle by the divider.
  localparam int DIV_STEPS = 4;

  // What the front end has decided about one item.
  typedef struct packed {
    logic                bad;
    logic [RADIX_W-1:0]  radix;
  } ritoa_kind_t;

  // Back end sequencer, one-hot.
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_READ = 4'b0100,
    ST_SEND = 4'b1000
  } ritoa_state_t;

  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] dw;
    dw = CHAR_W'(d);
    if (d > DIGIT_NINE) begin
      return dw + (ASCII_A - CHAR_W'(DIGIT_TEN));
    end
    return dw + ASCII_ZERO;
  endfunction

endpackage

>>> rtl/core/ritoa_ram.sv
`timescale 1ns / 1ps

module ritoa_ram #(
  parameter int WIDTH = 5,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> rtl/core/ritoa_fifo.sv
`timescale 1ns / 1ps

module ritoa_fifo #(
  parameter int WIDTH = 38,
  parameter int DEPTH = ritoa_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign full    = (fill == CNT_W'(DEPTH));
  assign empty   = (fill == '0);
  assign rd_data = slots[rd_ptr];

  // Pointers wrap naturally; the depth is a power of two.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (wr_en && !full) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (rd_en && !empty) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if ((wr_en && !full) && !(rd_en && !empty)) begin
        fill <= fill + CNT_W'(1);
      end else if (!(wr_en && !full) && (rd_en && !empty)) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && !full) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

>>> rtl/core/ritoa_front.sv
`timescale 1ns / 1ps

module ritoa_front #(
  parameter int VALUE_WIDTH = ritoa_pkg::VALUE_WIDTH_DEF
) (
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [ritoa_pkg::S_DATA_W-1:0]  s_tdata,
  output logic                            push,
  output ritoa_pkg::ritoa_kind_t          push_kind,
  output logic [VALUE_WIDTH-1:0]          push_value,
  input  logic                            q_full
);

  logic [ritoa_pkg::RADIX_W-1:0] radix_in;

  assign radix_in = s_tdata[ritoa_pkg::VALUE_IN_W +: ritoa_pkg::RADIX_W];

  assign s_tready = !q_full;
  assign push     = s_tvalid && !q_full;

  // Bits above the configured width are dropped; a wider width zero-extends.
  assign push_value      = VALUE_WIDTH'(s_tdata[ritoa_pkg::VALUE_IN_W-1:0]);
  assign push_kind.radix = radix_in;
  assign push_kind.bad   = (radix_in < ritoa_pkg::RADIX_MIN) ||
                           (radix_in > ritoa_pkg::RADIX_MAX);

endmodule

>>> rtl/core/ritoa_back.sv
`timescale 1ns / 1ps

module ritoa_back #(
  parameter int VALUE_WIDTH = ritoa_pkg::VALUE_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            q_empty,
  input  ritoa_pkg::ritoa_kind_t          q_kind,
  input  logic [VALUE_WIDTH-1:0]          q_value,
  output logic                            pop,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [ritoa_pkg::M_DATA_W-1:0]  m_tdata,
  output logic                            m_tlast,
  output logic                            m_tuser
);

  localparam int STEPS    = ritoa_pkg::DIV_STEPS;
  localparam int QW       = ((VALUE_WIDTH + STEPS - 1) / STEPS) * STEPS;
  localparam int DIV_CYC  = QW / STEPS;
  localparam int BCNT_W   = ($clog2(DIV_CYC) > 0) ? $clog2(DIV_CYC) : 1;
  localparam int IDX_W    = $clog2(VALUE_WIDTH);
  localparam int CNT_W    = $clog2(VALUE_WIDTH + 1);
  localparam int RW       = ritoa_pkg::RADIX_W;

  ritoa_pkg::ritoa_state_t state;

  logic [QW-1:0]     quo;
  logic [RW-1:0]     rem;
  logic [RW-1:0]     radix;
  logic [BCNT_W-1:0] bcnt;
  logic [CNT_W-1:0]  digit_count;
  logic [IDX_W-1:0]  idx;

  logic [QW-1:0]     div_q;
  logic [RW-1:0]     div_r;
  logic              div_last;
  logic              slot_free;
  logic              beat_load;
  logic              ram_we;
  logic [RW-1:0]     ram_rd_data;

  assign slot_free = !m_tvalid || m_tready;
  assign div_last  = (bcnt == BCNT_W'(DIV_CYC - 1));
  assign ram_we    = (state == ritoa_pkg::ST_DIV) && div_last;
  assign pop       = (state == ritoa_pkg::ST_IDLE) && !q_empty &&
                     (!q_kind.bad || slot_free);

  // A new output beat is loaded for an error answer or for the next digit.
  assign beat_load = ((state == ritoa_pkg::ST_IDLE) && !q_empty && q_kind.bad &&
                      slot_free) ||
                     ((state == ritoa_pkg::ST_SEND) && slot_free);

  // Restoring division, several quotient bits a cycle, MSB first.
  always_comb begin
    logic [QW-1:0] q_t;
    logic [RW-1:0] r_t;
    logic [RW:0]   rs;
    q_t = quo;
    r_t = rem;
    rs  = '0;
    for (int i = 0; i < STEPS; i++) begin
      rs  = {r_t, q_t[QW-1]};
      q_t = {q_t[QW-2:0], 1'b0};
      if (rs >= {1'b0, radix}) begin
        r_t    = RW'(rs - {1'b0, radix});
        q_t[0] = 1'b1;
      end else begin
        r_t = rs[RW-1:0];
      end
    end
    div_q = q_t;
    div_r = r_t;
  end

  ritoa_ram #(
    .WIDTH (RW),
    .DEPTH (VALUE_WIDTH)
  ) u_digits (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (digit_count[IDX_W-1:0]),
    .wr_data (div_r),
    .rd_addr (idx),
    .rd_data (ram_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ritoa_pkg::ST_IDLE;
      m_tvalid    <= 1'b0;
      quo         <= '0;
      digit_count <= '0;
      bcnt        <= '0;
      idx         <= '0;
    end else begin
      m_tvalid <= beat_load || (m_tvalid && !m_tready);
      case (state)
        ritoa_pkg::ST_IDLE: begin
          if (!q_empty && !q_kind.bad) begin
            quo         <= QW'(q_value);
            digit_count <= '0;
            bcnt        <= '0;
            state       <= ritoa_pkg::ST_DIV;
          end
        end
        ritoa_pkg::ST_DIV: begin
          quo <= div_q;
          if (div_last) begin
            bcnt        <= '0;
            digit_count <= digit_count + CNT_W'(1);
            if (div_q == '0) begin
              idx   <= digit_count[IDX_W-1:0];
              state <= ritoa_pkg::ST_READ;
            end
          end else begin
            bcnt <= bcnt + BCNT_W'(1);
          end
        end
        ritoa_pkg::ST_READ: begin
          state <= ritoa_pkg::ST_SEND;
        end
        ritoa_pkg::ST_SEND: begin
          if (slot_free) begin
            if (idx == '0) begin
              state <= ritoa_pkg::ST_IDLE;
            end else begin
              idx   <= idx - IDX_W'(1);
              state <= ritoa_pkg::ST_READ;
            end
          end
        end
        default: begin
          state <= ritoa_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk) begin
    case (state)
      ritoa_pkg::ST_IDLE: begin
        rem   <= '0;
        radix <= q_kind.radix;
        if (!q_empty && q_kind.bad && slot_free) begin
          m_tdata <= '0;
          m_tlast <= 1'b1;
          m_tuser <= 1'b1;
        end
      end
      ritoa_pkg::ST_DIV: begin
        rem <= div_last ? '0 : div_r;
      end
      ritoa_pkg::ST_SEND: begin
        if (slot_free) begin
          m_tdata <= ritoa_pkg::M_DATA_W'(ritoa_pkg::digit_to_ascii(ram_rd_data));
          m_tlast <= (idx == '0);
          m_tuser <= 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

>>> rtl/core/radix_integer_to_ascii.sv
`timescale 1ns / 1ps
// Channel  | Dir | Signals                          | Contents
// ---------+-----+----------------------------------+--------------------------------------
// s_ (in)  | in  | s_tvalid s_tready s_tdata[39:0]  | value [31:0], radix [36:32], zero pad
// m_ (out) | out | m_tvalid m_tready m_tdata[7:0]   | digit_char [6:0], zero pad;
//          |     | m_tlast m_tuser                  | tlast = last_digit, tuser = bad_radix
//
// A conversion runs each digit through the shared divider, four quotient bits per
// cycle, then reads each digit back from the digit RAM and sends it. A bad radix
// is answered with a single error beat.
// Reset is synchronous and clears the sequencer, the queue and the output beat.
// The two-entry queue lets new beats in while the back end divides or waits on a
// stalled output; the output register holds its beat until it is taken.

module radix_integer_to_ascii #(
  parameter int VALUE_WIDTH = ritoa_pkg::VALUE_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [ritoa_pkg::S_DATA_W-1:0]  s_tdata,   // value [31:0], radix [36:32]
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [ritoa_pkg::M_DATA_W-1:0]  m_tdata,   // digit_char [6:0]
  output logic                            m_tlast,
  output logic                            m_tuser    // bad_radix [0]
);

  localparam int KIND_W  = $bits(ritoa_pkg::ritoa_kind_t);
  localparam int ENTRY_W = KIND_W + VALUE_WIDTH;

  logic                   push;
  ritoa_pkg::ritoa_kind_t push_kind;
  logic [VALUE_WIDTH-1:0] push_value;
  logic                   q_full;
  logic                   q_empty;
  logic                   pop;
  logic [ENTRY_W-1:0]     q_rd_data;
  ritoa_pkg::ritoa_kind_t q_kind;
  logic [VALUE_WIDTH-1:0] q_value;

  // The front end checks the radix and trims the value before queueing it.
  ritoa_front #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_front (
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .push       (push),
    .push_kind  (push_kind),
    .push_value (push_value),
    .q_full     (q_full)
  );

  ritoa_fifo #(
    .WIDTH (ENTRY_W),
    .DEPTH (ritoa_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_data ({push_kind, push_value}),
    .full    (q_full),
    .rd_en   (pop),
    .rd_data (q_rd_data),
    .empty   (q_empty)
  );

  assign q_kind  = q_rd_data[ENTRY_W-1 -: KIND_W];
  assign q_value = q_rd_data[VALUE_WIDTH-1:0];

  // The back end divides, stores the digits and plays them out in reverse.
  ritoa_back #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_kind   (q_kind),
    .q_value  (q_value),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

>>> rtl/core/ritoa_checker.sv
`timescale 1ns / 1ps

module ritoa_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [ritoa_pkg::M_DATA_W-1:0] m_tdata,
  input logic                           m_tlast,
  input logic                           m_tuser
);

  localparam logic [ritoa_pkg::M_DATA_W-1:0] CH_0 = 8'h30;
  localparam logic [ritoa_pkg::M_DATA_W-1:0] CH_9 = 8'h39;
  localparam logic [ritoa_pkg::M_DATA_W-1:0] CH_A = 8'h41;
  localparam logic [ritoa_pkg::M_DATA_W-1:0] CH_P = 8'h50;

  // An error beat is the whole answer on its own.
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast && (m_tdata == '0))
    else $error("error beat without tlast or with a character");

  // Digit beats carry a character of some base up to 26.
  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |->
      ((m_tdata >= CH_0) && (m_tdata <= CH_9)) || ((m_tdata >= CH_A) && (m_tdata <= CH_P)))
    else $error("digit beat outside the digit alphabet");

  // A stalled beat keeps its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast) &&
      $stable(m_tuser))
    else $error("output beat changed while stalled");

  // Nothing comes out in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("output valid straight after reset");

endmodule

bind radix_integer_to_ascii ritoa_checker u_ritoa_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);

>>> dv/ritoa_digit_check.sv
`timescale 1ns / 1ps

module ritoa_digit_check (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  input  logic [ritoa_pkg::S_DATA_W-1:0] s_tdata,    // value [31:0], radix [36:32]
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic [ritoa_pkg::M_DATA_W-1:0] m_tdata,    // digit_char [6:0]
  input  logic                           m_tlast,
  input  logic                           m_tuser,    // bad_radix [0]
  output int                             failures,
  output int                             outstanding,
  output int                             numbers_seen,
  output int                             chars_checked,
  output int                             bad_radix_seen
);

  typedef struct packed {
    logic [ritoa_pkg::CHAR_W-1:0] digit_char;
    logic                         last_digit;
    logic                         bad_radix;
  } ascii_beat_t;

  ascii_beat_t expected_chars[$];

  // The block runs at its default width, which equals the port width, so no
  // bits of the value are dropped.
  task automatic predict_digits(input logic [ritoa_pkg::VALUE_IN_W-1:0] number,
                                input logic [ritoa_pkg::RADIX_W-1:0]    radix);
    logic [ritoa_pkg::VALUE_IN_W-1:0] quotient;
    logic [ritoa_pkg::RADIX_W-1:0]    digits[ritoa_pkg::VALUE_IN_W];
    logic [ritoa_pkg::RADIX_W-1:0]    d;
    int                               n;
    ascii_beat_t                      beat;
    quotient = number;
    n = 0;
    beat = '0;
    if (radix < ritoa_pkg::RADIX_MIN || radix > ritoa_pkg::RADIX_MAX) begin
      beat.last_digit = 1'b1;
      beat.bad_radix  = 1'b1;
      expected_chars.push_back(beat);
      bad_radix_seen++;
      return;
    end
    while (quotient != 0) begin
      digits[n] = ritoa_pkg::RADIX_W'(quotient % radix);
      quotient  = quotient / radix;
      n++;
    end
    if (n == 0) begin
      digits[0] = '0;
      n = 1;
    end
    for (int k = n - 1; k >= 0; k--) begin
      d = digits[k];
      if (d > ritoa_pkg::DIGIT_NINE) begin
        beat.digit_char = ritoa_pkg::CHAR_W'(d - ritoa_pkg::DIGIT_TEN) + ritoa_pkg::ASCII_A;
      end else begin
        beat.digit_char = ritoa_pkg::CHAR_W'(d) + ritoa_pkg::ASCII_ZERO;
      end
      beat.last_digit = (k == 0);
      beat.bad_radix  = 1'b0;
      expected_chars.push_back(beat);
    end
  endtask

  always @(posedge clk) begin : watch
    ascii_beat_t want;
    if (rst) begin
      expected_chars.delete();
    end else begin
      if (s_tvalid && s_tready) begin
        predict_digits(s_tdata[ritoa_pkg::VALUE_IN_W-1:0],
                       s_tdata[ritoa_pkg::VALUE_IN_W +: ritoa_pkg::RADIX_W]);
        numbers_seen++;
      end
      if (m_tvalid && m_tready) begin
        chars_checked++;
        if (expected_chars.size() == 0) begin
          failures++;
          $display("%0t: unexpected beat, expected none, got tdata %h last %b user %b",
                   $time, m_tdata, m_tlast, m_tuser);
        end else begin
          want = expected_chars.pop_front();
          if (m_tdata != ritoa_pkg::M_DATA_W'(want.digit_char) ||
              m_tlast != want.last_digit || m_tuser != want.bad_radix) begin
            failures++;
            $display({"%0t: mismatch, expected tdata %h last %b user %b, ",
                      "got tdata %h last %b user %b"},
                     $time, ritoa_pkg::M_DATA_W'(want.digit_char), want.last_digit,
                     want.bad_radix, m_tdata, m_tlast, m_tuser);
          end
        end
      end
    end
    outstanding = expected_chars.size();
  end

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps

module tb;

  // The slowest legal run is roughly 230 numbers of 32 digits each, with a
  // random output stall before every digit. The limit leaves ample headroom.
  localparam int LIMIT_CYCLES   = 1_000_000;
  localparam int RANDOM_NUMBERS = 210;
  // Settles any tail left after the longest conversion.
  localparam int DRAIN_CYCLES   = 400;

  logic                           clk;
  logic                           rst;
  logic                           s_tvalid;
  logic                           s_tready;
  logic [ritoa_pkg::S_DATA_W-1:0] s_tdata;    // value [31:0], radix [36:32], zero pad
  logic                           m_tvalid;
  logic                           m_tready;
  logic [ritoa_pkg::M_DATA_W-1:0] m_tdata;    // digit_char [6:0], zero pad
  logic                           m_tlast;
  logic                           m_tuser;    // bad_radix [0]

  // Handshake flags registered at the rising edge, so that the drivers, which
  // work on the falling edge, see whether a beat was taken without a race.
  logic                  s_fire;
  logic                  m_fire;

  // While set, neither the sender nor the receiver inserts idle cycles.
  logic                  calm;

  int                    failures;
  int                    outstanding;
  int                    numbers_seen;
  int                    chars_checked;
  int                    bad_radix_seen;
  int                    cycles;

  radix_integer_to_ascii DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  ritoa_digit_check watcher (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tlast        (m_tlast),
    .m_tuser        (m_tuser),
    .failures       (failures),
    .outstanding    (outstanding),
    .numbers_seen   (numbers_seen),
    .chars_checked  (chars_checked),
    .bad_radix_seen (bad_radix_seen)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    s_fire <= s_tvalid && s_tready;
    m_fire <= m_tvalid && m_tready;
  end

  // Watchdog: a hung block must not leave the run spinning for ever.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("tb failed");
      $finish;
    end
  end

  // Offers one number and waits until the block takes the beat. A random gap
  // comes first unless the calm stretch is active.
  task automatic send_number(input logic [ritoa_pkg::VALUE_IN_W-1:0] number,
                             input logic [ritoa_pkg::RADIX_W-1:0]    radix);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(ritoa_pkg::S_DATA_W - ritoa_pkg::VALUE_IN_W - ritoa_pkg::RADIX_W){1'b0}},
                 radix, number};
    do @(negedge clk); while (!s_fire);
  endtask

  // Holds the input back until every predicted character has come out, so
  // that the block is seen starting again from an empty pipeline.
  task automatic hold_until_drained();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
  endtask

  // Receiver: before each beat it stays not ready for a random number of
  // cycles, then waits, ready, until a beat is taken.
  initial begin : sink
    int stall;
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(negedge clk); while (!m_fire);
    end
  end

  initial begin : stimulus
    logic [ritoa_pkg::VALUE_IN_W-1:0] number;
    logic [ritoa_pkg::RADIX_W-1:0]    radix;
    logic [63:0]                      power;
    int                               pick;
    int                               sub;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    calm     = 1'b0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed cases: zero, the longest and shortest digit strings, both ends
    // of the valid radix range, letters as digits, and invalid radices.
    send_number('0, 5'd10);
    send_number('0, ritoa_pkg::RADIX_MIN);
    send_number('1, ritoa_pkg::RADIX_MIN);
    send_number(32'h8000_0000, ritoa_pkg::RADIX_MIN);
    send_number(32'd1, ritoa_pkg::RADIX_MIN);
    send_number('1, ritoa_pkg::RADIX_MAX);
    send_number(32'd25, ritoa_pkg::RADIX_MAX);
    send_number(32'd26, ritoa_pkg::RADIX_MAX);
    send_number(32'd10, 5'd11);
    send_number(32'd9, 5'd10);
    send_number(32'd1234567890, 5'd10);
    send_number(32'hDEAD_BEEF, 5'd16);
    send_number(32'h7FFF_FFFF, 5'd3);
    send_number(32'h5555_5555, 5'd7);
    send_number(32'hAAAA_AAAA, 5'd13);
    send_number('1, '0);
    send_number(32'd5, ritoa_pkg::RADIX_MIN - 5'd1);
    send_number('0, ritoa_pkg::RADIX_MAX + 5'd1);
    send_number('1, '1);
    hold_until_drained();

    // Random part: mostly valid radices with values spread over full-width,
    // small, radix-power boundaries and extremes, plus a share of bad radices.
    for (int k = 0; k < RANDOM_NUMBERS; k++) begin
      calm = (k % 50) >= 40;
      if (k == RANDOM_NUMBERS / 2) begin
        hold_until_drained();
      end
      pick  = $urandom_range(0, 99);
      radix = ritoa_pkg::RADIX_W'($urandom_range(ritoa_pkg::RADIX_MIN, ritoa_pkg::RADIX_MAX));
      if (pick < 8) begin
        // One of 0, 1 or the values above the top of the range.
        sub    = $urandom_range(0, 6);
        radix  = (sub < 2) ? ritoa_pkg::RADIX_W'(sub) :
                             ritoa_pkg::RADIX_W'(ritoa_pkg::RADIX_MAX + sub - 1);
        number = $urandom;
      end else if (pick < 45) begin
        number = $urandom;
      end else if (pick < 65) begin
        number = $urandom_range(0, 1000);
      end else if (pick < 85) begin
        // A power of the radix, or one less, where the digit count changes.
        power = 64'd1;
        repeat ($urandom_range(1, 31)) begin
          if (power * radix <= 64'hFFFF_FFFF) begin
            power = power * radix;
          end
        end
        number = $urandom_range(0, 1) ? power[ritoa_pkg::VALUE_IN_W-1:0] :
                                        power[ritoa_pkg::VALUE_IN_W-1:0] - 1;
      end else if (pick < 93) begin
        number = $urandom_range(0, 1) ? '1 : '0;
      end else begin
        number = $urandom >> $urandom_range(0, 31);
      end
      send_number(number, radix);
    end

    hold_until_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Converted %0d numbers over radices 0 to 31, %0d of them with an invalid radix.",
             numbers_seen, bad_radix_seen);
    $display("Checked %0d output characters under random idling on both channels.",
             chars_checked);
    if (failures == 0 && outstanding == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
